/* hdl/srva_pkg.sv */
package srva_pkg;

  // Number of section slots, one cell of the search chain per slot.
  localparam int unsigned MAX_SECTIONS = 16;
  // Width of the per-request countdown of slots still to be searched.
  localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SECT_CNT_W  = 5;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic KIND_LOAD      = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE     = 2'd2;

  typedef enum logic [1:0] {
    REGION_HEADER   = 2'd0,
    REGION_HIT      = 2'd1,
    REGION_PADDING  = 2'd2,
    REGION_UNMAPPED = 2'd3
  } region_e;

  // One section entry as it arrives with a load request.
  typedef struct packed {
    logic [ADDR_W-1:0] virt_start;
    logic [ADDR_W-1:0] virt_length;
    logic [ADDR_W-1:0] raw_length;
    logic [ADDR_W-1:0] raw_start;
  } entry_t;

  // Translate request travelling down the chain of cells.
  typedef struct packed {
    logic              done;
    logic [CNT_W-1:0]  remaining;
    logic [ADDR_W-1:0] rva;
    region_e           region;
    logic [ADDR_W-1:0] offset;
  } token_t;

endpackage

/* hdl/srva_cell.sv */
module srva_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_en_i,
  input  srva_pkg::entry_t  load_entry_i,
  input  logic              tok_valid_i,
  input  srva_pkg::token_t  tok_i,
  output logic              tok_valid_o,
  output srva_pkg::token_t  tok_o
);

  // The entry is kept in a form that lets every test run in parallel:
  // both ends at 33 bits so they never wrap, and the start-to-raw bias.
  logic [srva_pkg::ADDR_W-1:0] vstart_q, vstart_d;
  logic [srva_pkg::ADDR_W:0]   vend_q, vend_d;
  logic [srva_pkg::ADDR_W:0]   rend_q, rend_d;
  logic [srva_pkg::ADDR_W-1:0] bias_q, bias_d;

  logic                        tok_valid_q;
  srva_pkg::token_t            tok_q, tok_d;
  logic                        active;
  logic                        hit;
  logic                        pad;
  logic [srva_pkg::ADDR_W:0]   rva_ext;

  always_comb begin
    vstart_d = load_entry_i.virt_start;
    vend_d   = {1'b0, load_entry_i.virt_start} + {1'b0, load_entry_i.virt_length};
    rend_d   = {1'b0, load_entry_i.virt_start} + {1'b0, load_entry_i.raw_length};
    bias_d   = load_entry_i.raw_start - load_entry_i.virt_start;
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      vstart_q <= vstart_d;
      vend_q   <= vend_d;
      rend_q   <= rend_d;
      bias_q   <= bias_d;
    end
  end

  always_comb begin
    rva_ext = {1'b0, tok_i.rva};
    active  = (tok_i.remaining != '0);
    hit     = !tok_i.done && active && (tok_i.rva >= vstart_q) && (rva_ext < vend_q);
    pad     = (rva_ext >= rend_q);

    tok_d = tok_i;
    if (active) begin
      tok_d.remaining = tok_i.remaining - srva_pkg::CNT_W'(1);
    end
    if (hit) begin
      tok_d.done = 1'b1;
      if (pad) begin
        tok_d.region = srva_pkg::REGION_PADDING;
        tok_d.offset = '0;
      end else begin
        tok_d.region = srva_pkg::REGION_HIT;
        tok_d.offset = tok_i.rva + bias_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

/* hdl/section_rva_to_file_offset.sv */
// Section RVA to file offset translator.
//
// Requests enter on start_i and are taken at a rising edge where start_i is
// high and busy_o is low. kind_i selects the request type. A load request
// writes one section entry into the slot given by section_slot_i and
// produces no result. A translate request maps rel_addr_i to a file offset
// and produces exactly one result. A translate request walks a chain of
// MAX_SECTIONS cells, one cell per slot, each comparing the address against
// its own entry while the earliest hit is kept. The result strobe
// result_valid_o rises once the request has passed the injection register,
// every cell and the result register, and lasts one cycle; busy_o drops in
// that same cycle so the next request can be taken at the edge that ends it.
// The receiver cannot stall: every result must be captured during its
// strobe. The configuration channel (cfg_valid_i/cfg_ready_o) is always
// ready; the user must write it only while the block is idle, which the
// block itself does not enforce. Reset clears the configuration registers
// and drains the chain; section entries are undefined until loaded.
module section_rva_to_file_offset (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            kind_i,
  input  logic [srva_pkg::SLOT_W-1:0]     section_slot_i,
  input  logic [srva_pkg::ADDR_W-1:0]     virt_start_i,
  input  logic [srva_pkg::ADDR_W-1:0]     virt_length_i,
  input  logic [srva_pkg::ADDR_W-1:0]     raw_length_i,
  input  logic [srva_pkg::ADDR_W-1:0]     raw_start_i,
  input  logic [srva_pkg::ADDR_W-1:0]     rel_addr_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srva_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srva_pkg::ADDR_W-1:0]     cfg_data_i,
  output logic                            result_valid_o,
  output logic [srva_pkg::ADDR_W-1:0]     file_offset_o,
  output logic [1:0]                      region_o,
  output logic                            pointer_valid_o
);

  localparam int unsigned N = srva_pkg::MAX_SECTIONS;

  // Configuration registers.
  logic [srva_pkg::ADDR_W-1:0]     header_size_q;
  logic [srva_pkg::SECT_CNT_W-1:0] section_count_q;
  logic [srva_pkg::ADDR_W-1:0]     file_size_q;
  logic                            cfg_write;

  // Request acceptance and chain control.
  logic                            accept;
  logic                            accept_load;
  logic                            accept_xlate;
  logic                            busy_q, busy_d;
  logic [srva_pkg::CNT_W-1:0]      search_limit;
  srva_pkg::entry_t                load_entry;
  srva_pkg::token_t                inject_d;
  logic                            inject_valid_q;
  srva_pkg::token_t                inject_q;
  logic [N-1:0]                    load_en;

  // Chain links: link 0 is the injection register, link N the last cell.
  logic [N:0]                      chain_valid;
  srva_pkg::token_t                chain_tok [N+1];

  // Result register.
  logic                            res_valid_q;
  logic [srva_pkg::ADDR_W-1:0]     res_offset_q;
  srva_pkg::region_e               res_region_q;
  logic                            res_ptr_ok_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_size_q   <= '0;
      section_count_q <= '0;
      file_size_q     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        srva_pkg::CFG_HEADER_SIZE:   header_size_q   <= cfg_data_i;
        srva_pkg::CFG_SECTION_COUNT: section_count_q <= cfg_data_i[srva_pkg::SECT_CNT_W-1:0];
        srva_pkg::CFG_FILE_SIZE:     file_size_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept       = start_i && !busy_q;
  assign accept_load  = accept && (kind_i == srva_pkg::KIND_LOAD);
  assign accept_xlate = accept && (kind_i == srva_pkg::KIND_TRANSLATE);

  // A section count above the number of slots searches every slot.
  always_comb begin
    if (32'(section_count_q) > 32'(N)) begin
      search_limit = srva_pkg::CNT_W'(N);
    end else begin
      search_limit = srva_pkg::CNT_W'(section_count_q);
    end
  end

  // Header addresses are resolved before the chain; the token still walks
  // through it but is already marked done, so no cell changes its result.
  always_comb begin
    inject_d.rva       = rel_addr_i;
    inject_d.remaining = search_limit;
    if (rel_addr_i < header_size_q) begin
      inject_d.done   = 1'b1;
      inject_d.region = srva_pkg::REGION_HEADER;
      inject_d.offset = rel_addr_i;
    end else begin
      inject_d.done   = 1'b0;
      inject_d.region = srva_pkg::REGION_UNMAPPED;
      inject_d.offset = '0;
    end
  end

  // The block holds one translate request at a time; busy covers it from
  // acceptance until the result register is loaded.
  always_comb begin
    if (busy_q) begin
      busy_d = !chain_valid[N];
    end else begin
      busy_d = accept_xlate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      inject_valid_q <= 1'b0;
    end else begin
      busy_q         <= busy_d;
      inject_valid_q <= accept_xlate;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_xlate) begin
      inject_q <= inject_d;
    end
  end

  assign busy_o = busy_q;

  assign load_entry.virt_start  = virt_start_i;
  assign load_entry.virt_length = virt_length_i;
  assign load_entry.raw_length  = raw_length_i;
  assign load_entry.raw_start   = raw_start_i;

  assign chain_valid[0] = inject_valid_q;
  assign chain_tok[0]   = inject_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign load_en[i] = accept_load && (32'(section_slot_i) == 32'(i));

    srva_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_en_i    (load_en[i]),
      .load_entry_i (load_entry),
      .tok_valid_i  (chain_valid[i]),
      .tok_i        (chain_tok[i]),
      .tok_valid_o  (chain_valid[i+1]),
      .tok_o        (chain_tok[i+1])
    );
  end

  // The last link carries the final answer; the pointer check against the
  // file size is applied on the way into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= chain_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[N]) begin
      res_offset_q <= chain_tok[N].offset;
      res_region_q <= chain_tok[N].region;
      res_ptr_ok_q <= (chain_tok[N].offset != '0) && (chain_tok[N].offset < file_size_q);
    end
  end

  assign result_valid_o  = res_valid_q;
  assign file_offset_o   = res_offset_q;
  assign region_o        = res_region_q;
  assign pointer_valid_o = res_ptr_ok_q;

`ifndef SYNTH
  // Only one translate request may be in the chain at any time.
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one request in the search chain");

  // An idle block has an empty chain.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (chain_valid == '0))
    else $error("chain holds a request while idle");

  // A result only follows a request that held the block busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_q))
    else $error("result without a request in flight");

  // A valid pointer is never zero.
  a_ptr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pointer_valid_o) |-> (file_offset_o != '0))
    else $error("pointer flagged valid with zero offset");

  // Padding and unmapped addresses give offset zero.
  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ((res_region_q == srva_pkg::REGION_PADDING) ||
                        (res_region_q == srva_pkg::REGION_UNMAPPED)))
      |-> (file_offset_o == '0))
    else $error("nonzero offset for padding or unmapped address");
`endif

endmodule
